// ===== rtl/ltu_pkg.sv =====
// Package with shared widths, byte codes and types of the legacy text transcoder.
`timescale 1ns / 1ps

package ltu_pkg;

    // Field widths and result depth.
    localparam int ByteW      = 8;
    localparam int SkipW      = 2;
    localparam int MaxResults = 4;
    localparam int CountW     = 3;

    // Byte codes of the legacy format and of UTF-8.
    localparam logic [ByteW-1:0] MarkA      = 8'hE5;
    localparam logic [ByteW-1:0] MarkB      = 8'hE6;
    localparam logic [ByteW-1:0] LeadC1     = 8'hC1;
    localparam logic [ByteW-1:0] DegreeHi   = 8'hC2;
    localparam logic [ByteW-1:0] DegreeLo   = 8'hB0;
    localparam logic [ByteW-1:0] EuroLead   = 8'hAC;
    localparam logic [ByteW-1:0] EuroMid    = 8'h82;
    localparam logic [ByteW-1:0] TabLead    = 8'hC4;
    localparam logic [ByteW-1:0] TabSecond  = 8'h04;
    localparam logic [ByteW-1:0] C1OrMask   = 8'h02;
    localparam logic [ByteW-1:0] C1AndMask  = 8'hBF;
    localparam logic [ByteW-1:0] LeadOrMask = 8'hC0;
    localparam logic [ByteW-1:0] EuroFirst  = 8'hE2;
    localparam logic [ByteW-1:0] TabCode    = 8'h09;
    localparam logic [ByteW-1:0] NewLine    = 8'h0A;
    localparam logic [SkipW-1:0] MarkTail   = 2'd2;

    // The bytes that one request turns into, first byte at index 0.
    typedef struct packed {
        logic [CountW-1:0]                count;
        logic [MaxResults-1:0][ByteW-1:0] bytes;
    } ltu_result_t;

endpackage

// ===== rtl/ltu_if.sv =====
// Valid/ready channel interfaces for the input and output requests of the transcoder.
`timescale 1ns / 1ps

interface ltu_in_if;
    logic                     valid;
    logic                     ready;
    logic [ltu_pkg::ByteW-1:0] in_byte;
    logic                     line_last;

    modport source (output valid, output in_byte, output line_last, input ready);
    modport sink   (input valid, input in_byte, input line_last, output ready);
endinterface

interface ltu_out_if;
    logic                     valid;
    logic                     ready;
    logic [ltu_pkg::ByteW-1:0] out_byte;
    logic                     run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== rtl/legacy_text_to_utf8_transcoder_unit.sv =====
// Top level of the legacy text to UTF-8 transcoder: input register, decode, result buffer.
`timescale 1ns / 1ps

// Each input request carries one byte of a legacy text line and a last-of-line flag;
// the block answers with zero to four UTF-8 bytes, run_last marking the final byte
// of each request's answer. An input request is registered, decoded combinationally
// into a four-byte result buffer, and the buffer hands out one byte per cycle while
// the output is ready. A request holds the result buffer until its last byte is
// taken, and the next request loads as that byte leaves, so the block takes a new
// request every cycle for plain text while the output is ready, and waits while a
// longer answer, such as an expanded pair with a newline, drains; the output port of
// the result buffer is what sets that pace.
module legacy_text_to_utf8_transcoder_unit (
    input  logic      clk,
    input  logic      rst_n,
    ltu_in_if.sink    in_ch,
    ltu_out_if.source out_ch
);

    // Input register.
    logic                      in_valid_reg;
    logic [ltu_pkg::ByteW-1:0] in_byte_reg;
    logic                      in_last_reg;

    // Decode state.
    logic [ltu_pkg::ByteW-1:0] held_lead_reg, held_lead_next;
    logic                      lead_valid_reg, lead_valid_next;
    logic [ltu_pkg::SkipW-1:0] skip_left_reg, skip_left_next;

    // Result buffer.
    logic [ltu_pkg::CountW-1:0]                        cnt_reg;
    logic [ltu_pkg::MaxResults-1:0][ltu_pkg::ByteW-1:0] buf_reg;

    ltu_pkg::ltu_result_t dec;
    logic                 pop;
    logic                 buf_free;
    logic                 move;
    logic                 in_fire;

    // Handshake control.
    assign pop      = out_ch.valid && out_ch.ready;
    assign buf_free = (cnt_reg == '0) || ((cnt_reg == ltu_pkg::CountW'(1)) && out_ch.ready);
    assign move     = in_valid_reg && buf_free;
    assign in_ch.ready = !in_valid_reg || buf_free;
    assign in_fire  = in_ch.valid && in_ch.ready;

    assign out_ch.valid    = (cnt_reg != '0);
    assign out_ch.out_byte = buf_reg[0];
    assign out_ch.run_last = (cnt_reg == ltu_pkg::CountW'(1));

    // Decode of the registered byte against the held state.
    always_comb
    begin
        logic [ltu_pkg::CountW-1:0] n;
        logic [ltu_pkg::ByteW-1:0]  b;
        n               = '0;
        b               = in_byte_reg;
        dec.bytes       = '0;
        held_lead_next  = held_lead_reg;
        lead_valid_next = lead_valid_reg;
        skip_left_next  = skip_left_reg;

        if (skip_left_reg != '0)
        begin
            skip_left_next = skip_left_reg - ltu_pkg::SkipW'(1);
        end
        else if (lead_valid_reg)
        begin
            lead_valid_next = 1'b0;
            held_lead_next  = '0;
            if ((held_lead_reg == ltu_pkg::LeadC1) && (b == ltu_pkg::DegreeLo))
            begin
                dec.bytes[0] = ltu_pkg::DegreeHi;
                dec.bytes[1] = ltu_pkg::DegreeLo;
                n            = ltu_pkg::CountW'(2);
            end
            else if ((held_lead_reg == ltu_pkg::EuroLead) && (b == ltu_pkg::EuroMid))
            begin
                dec.bytes[0] = ltu_pkg::EuroFirst;
                dec.bytes[1] = ltu_pkg::EuroMid;
                dec.bytes[2] = ltu_pkg::EuroLead;
                n            = ltu_pkg::CountW'(3);
            end
            else if ((held_lead_reg == ltu_pkg::TabLead) && (b == ltu_pkg::TabSecond))
            begin
                dec.bytes[0] = ltu_pkg::TabCode;
                n            = ltu_pkg::CountW'(1);
            end
            else if (held_lead_reg == ltu_pkg::LeadC1)
            begin
                dec.bytes[0] = held_lead_reg | ltu_pkg::C1OrMask;
                dec.bytes[1] = b & ltu_pkg::C1AndMask;
                n            = ltu_pkg::CountW'(2);
            end
            else
            begin
                dec.bytes[0] = b | ltu_pkg::LeadOrMask;
                dec.bytes[1] = held_lead_reg;
                n            = ltu_pkg::CountW'(2);
            end
        end
        else if ((b == ltu_pkg::MarkA) || (b == ltu_pkg::MarkB))
        begin
            skip_left_next = ltu_pkg::MarkTail;
        end
        else if (b[ltu_pkg::ByteW-1])
        begin
            held_lead_next  = b;
            lead_valid_next = 1'b1;
        end
        else
        begin
            dec.bytes[0] = b;
            n            = ltu_pkg::CountW'(1);
        end

        // End of line appends a newline and clears all state.
        if (in_last_reg)
        begin
            for (int i = 0; i < ltu_pkg::MaxResults; i++)
            begin
                if (n == ltu_pkg::CountW'(i))
                begin
                    dec.bytes[i] = ltu_pkg::NewLine;
                end
            end
            n               = n + ltu_pkg::CountW'(1);
            held_lead_next  = '0;
            lead_valid_next = 1'b0;
            skip_left_next  = '0;
        end
        dec.count = n;
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (move)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= in_ch.in_byte;
            in_last_reg <= in_ch.line_last;
        end
    end

    // Decode state update when a request leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_lead_reg  <= '0;
            lead_valid_reg <= 1'b0;
            skip_left_reg  <= '0;
        end
        else if (move)
        begin
            held_lead_reg  <= held_lead_next;
            lead_valid_reg <= lead_valid_next;
            skip_left_reg  <= skip_left_next;
        end
    end

    // Result buffer count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (move)
        begin
            cnt_reg <= dec.count;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - ltu_pkg::CountW'(1);
        end
    end

    // Result buffer bytes: load on decode, shift down on each output request.
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            buf_reg <= dec.bytes;
        end
        else if (pop)
        begin
            for (int i = 0; i < ltu_pkg::MaxResults - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

    // The result buffer never holds more than four bytes.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ltu_pkg::CountW'(ltu_pkg::MaxResults))
        else $error("result buffer count out of range");

    // A held lead byte and a format mark are never pending together.
    a_state_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(lead_valid_reg && (skip_left_reg != '0)))
        else $error("lead byte and format mark pending together");

    // The end of a line leaves the decode state clear.
    a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        move && in_last_reg |=> !lead_valid_reg && (skip_left_reg == '0))
        else $error("state not cleared at end of line");

    // A decoded request never overwrites bytes still waiting in the buffer.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        move |-> (cnt_reg == '0) || (pop && (cnt_reg == ltu_pkg::CountW'(1))))
        else $error("result buffer overwritten");

endmodule

// ===== tb/sv/legacy_text_to_utf8_transcoder_unit_test.sv =====
// Self-checking testbench of the legacy text to UTF-8 transcoder with random handshakes.
`timescale 1ns / 1ps

module legacy_text_to_utf8_transcoder_unit_test;

    localparam int ItemGoal = 330;
    localparam int IdlePct = 34;
    localparam int SteadyFrom = 250;
    localparam int SteadyTo = 650;
    localparam int DrainCycles = 12;

    typedef struct packed {
        logic [ltu_pkg::ByteW-1:0] code;
        logic                      last;
    } legacy_item_t;

    typedef struct packed {
        logic [ltu_pkg::ByteW-1:0] code;
        logic                      last;
    } utf8_item_t;

    logic clk;
    logic rst_n;

    ltu_in_if  in_ch ();
    ltu_out_if out_ch ();

    legacy_text_to_utf8_transcoder_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Requests waiting to be driven and UTF-8 bytes waiting to come out.
    legacy_item_t legacy_bytes[$];
    utf8_item_t   utf8_due[$];

    // Decoder state as the block should hold it.
    logic [ltu_pkg::ByteW-1:0] held_lead;
    logic                      lead_valid;
    logic [ltu_pkg::SkipW-1:0] skip_left;

    legacy_item_t next_req;
    logic         in_taken;
    int           cycle_no;
    int           queued_total;
    int           bytes_sent;
    int           lines_sent;
    int           utf8_checked;
    int           mismatches;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Random idling on either side, except during one steady stretch.
    function automatic bit idle_now();
        if (cycle_no >= SteadyFrom && cycle_no < SteadyTo)
            return 1'b0;
        return $urandom_range(0, 99) < IdlePct;
    endfunction

    task automatic report_mismatch(input string what, input logic [ltu_pkg::ByteW-1:0] got,
                                   input logic [ltu_pkg::ByteW-1:0] want);
        $display("MISMATCH at output byte %0d: %s got %02h expected %02h",
                 utf8_checked, what, got, want);
        mismatches++;
    endtask

    task automatic put_legacy(input logic [ltu_pkg::ByteW-1:0] code, input logic last);
        legacy_item_t req;
        req.code = code;
        req.last = last;
        legacy_bytes.push_back(req);
        queued_total++;
    endtask

    // Works out the UTF-8 bytes that one accepted legacy byte produces.
    function automatic void transcode_byte(input logic [ltu_pkg::ByteW-1:0] b,
                                           input logic last);
        logic [ltu_pkg::ByteW-1:0] run_q[$];
        utf8_item_t                ent;
        if (skip_left != '0)
        begin
            skip_left = skip_left - 1'b1;
        end
        else if (lead_valid)
        begin
            if (held_lead == ltu_pkg::LeadC1 && b == ltu_pkg::DegreeLo)
            begin
                run_q.push_back(ltu_pkg::DegreeHi);
                run_q.push_back(ltu_pkg::DegreeLo);
            end
            else if (held_lead == ltu_pkg::EuroLead && b == ltu_pkg::EuroMid)
            begin
                run_q.push_back(ltu_pkg::EuroFirst);
                run_q.push_back(ltu_pkg::EuroMid);
                run_q.push_back(ltu_pkg::EuroLead);
            end
            else if (held_lead == ltu_pkg::TabLead && b == ltu_pkg::TabSecond)
            begin
                run_q.push_back(ltu_pkg::TabCode);
            end
            else if (held_lead == ltu_pkg::LeadC1)
            begin
                run_q.push_back(held_lead | ltu_pkg::C1OrMask);
                run_q.push_back(b & ltu_pkg::C1AndMask);
            end
            else
            begin
                run_q.push_back(b | ltu_pkg::LeadOrMask);
                run_q.push_back(held_lead);
            end
            lead_valid = 1'b0;
            held_lead = '0;
        end
        else if (b == ltu_pkg::MarkA || b == ltu_pkg::MarkB)
        begin
            skip_left = ltu_pkg::MarkTail;
        end
        else if (b[ltu_pkg::ByteW-1])
        begin
            held_lead = b;
            lead_valid = 1'b1;
        end
        else
        begin
            run_q.push_back(b);
        end

        // End of line: newline out, all decoder state cleared.
        if (last)
        begin
            run_q.push_back(ltu_pkg::NewLine);
            held_lead = '0;
            lead_valid = 1'b0;
            skip_left = '0;
        end

        foreach (run_q[i])
        begin
            ent.code = run_q[i];
            ent.last = (i == run_q.size() - 1);
            utf8_due.push_back(ent);
        end
    endfunction

    // Request driver: presents the next pending byte unless it takes a break.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || in_taken)
            begin
                if (legacy_bytes.size() != 0 && !idle_now())
                begin
                    next_req = legacy_bytes.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.in_byte <= next_req.code;
                    in_ch.line_last <= next_req.last;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= !idle_now();
        end
    end

    // Monitor: predicts on accepted requests and checks every output byte.
    always @(posedge clk or negedge rst_n)
    begin
        utf8_item_t want;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
            held_lead = '0;
            lead_valid = 1'b0;
            skip_left = '0;
        end
        else
        begin
            cycle_no++;
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
            begin
                transcode_byte(in_ch.in_byte, in_ch.line_last);
                bytes_sent++;
                if (in_ch.line_last)
                    lines_sent++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (utf8_due.size() == 0)
                begin
                    report_mismatch("unexpected byte", out_ch.out_byte, '0);
                end
                else
                begin
                    want = utf8_due.pop_front();
                    if (out_ch.out_byte !== want.code)
                        report_mismatch("out_byte", out_ch.out_byte, want.code);
                    if (out_ch.run_last !== want.last)
                        report_mismatch("run_last", ltu_pkg::ByteW'(out_ch.run_last),
                                        ltu_pkg::ByteW'(want.last));
                end
                utf8_checked++;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        logic [ltu_pkg::ByteW-1:0] line_q[$];
        logic [ltu_pkg::ByteW-1:0] lead;
        int                        n_tok;
        int                        keep;

        in_ch.valid = 1'b0;
        in_ch.in_byte = '0;
        in_ch.line_last = 1'b0;
        out_ch.ready = 1'b0;
        rst_n = 1'b0;
        cycle_no = 0;
        queued_total = 0;
        bytes_sent = 0;
        lines_sent = 0;
        utf8_checked = 0;
        mismatches = 0;

        // Directed lines: plain extremes, each special pair, marks and cut sequences.
        put_legacy(8'h00, 1'b0);
        put_legacy(8'h7F, 1'b1);
        put_legacy(ltu_pkg::LeadC1, 1'b0);
        put_legacy(ltu_pkg::DegreeLo, 1'b0);
        put_legacy(ltu_pkg::EuroLead, 1'b0);
        put_legacy(ltu_pkg::EuroMid, 1'b0);
        put_legacy(ltu_pkg::TabLead, 1'b0);
        put_legacy(ltu_pkg::TabSecond, 1'b1);
        put_legacy(ltu_pkg::LeadC1, 1'b0);
        put_legacy(8'hFF, 1'b0);
        // A mark byte taken as the second byte of a pair.
        put_legacy(8'h80, 1'b0);
        put_legacy(ltu_pkg::MarkA, 1'b0);
        // A mark whose body holds a lead byte and another mark byte.
        put_legacy(ltu_pkg::MarkA, 1'b0);
        put_legacy(ltu_pkg::LeadC1, 1'b0);
        put_legacy(ltu_pkg::MarkB, 1'b0);
        put_legacy(8'h55, 1'b0);
        // Lead byte left dangling at the end of the line.
        put_legacy(8'hFF, 1'b1);
        // Mark cut by the end of the line; the next line starts clean.
        put_legacy(ltu_pkg::MarkB, 1'b0);
        put_legacy(8'h12, 1'b1);
        put_legacy(8'h41, 1'b0);
        put_legacy(ltu_pkg::TabLead, 1'b0);
        put_legacy(8'h05, 1'b1);

        // Random lines built from well-formed pieces, with noise and cut lines.
        while (queued_total < ItemGoal)
        begin
            line_q.delete();
            n_tok = $urandom_range(1, 6);
            repeat (n_tok)
            begin
                case ($urandom_range(0, 11))
                    0, 1, 2, 3: line_q.push_back(ltu_pkg::ByteW'($urandom_range(0, 127)));
                    4:
                    begin
                        line_q.push_back(ltu_pkg::LeadC1);
                        line_q.push_back(ltu_pkg::DegreeLo);
                    end
                    5:
                    begin
                        line_q.push_back(ltu_pkg::EuroLead);
                        line_q.push_back(ltu_pkg::EuroMid);
                    end
                    6:
                    begin
                        line_q.push_back(ltu_pkg::TabLead);
                        line_q.push_back(ltu_pkg::TabSecond);
                    end
                    7:
                    begin
                        line_q.push_back(ltu_pkg::LeadC1);
                        line_q.push_back(ltu_pkg::ByteW'($urandom_range(0, 255)));
                    end
                    8, 9:
                    begin
                        do
                            lead = ltu_pkg::ByteW'($urandom_range(128, 255));
                        while (lead == ltu_pkg::MarkA || lead == ltu_pkg::MarkB);
                        line_q.push_back(lead);
                        line_q.push_back(ltu_pkg::ByteW'($urandom_range(0, 255)));
                    end
                    10:
                    begin
                        line_q.push_back($urandom_range(0, 1) ? ltu_pkg::MarkA
                                                              : ltu_pkg::MarkB);
                        line_q.push_back(ltu_pkg::ByteW'($urandom_range(0, 255)));
                        line_q.push_back(ltu_pkg::ByteW'($urandom_range(0, 255)));
                    end
                    default: line_q.push_back(ltu_pkg::ByteW'($urandom_range(0, 255)));
                endcase
            end
            keep = line_q.size();
            if ($urandom_range(0, 5) == 0)
                keep = $urandom_range(1, line_q.size());
            for (int i = 0; i < keep; i++)
                put_legacy(line_q[i], i == keep - 1);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (legacy_bytes.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (utf8_due.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Run covered %0d legacy bytes in %0d lines and checked %0d UTF-8 bytes.",
                 bytes_sent, lines_sent, utf8_checked);
        $display("Mismatches found: %0d.", mismatches);
        if (mismatches == 0)
            $display("legacy_text_to_utf8_transcoder_unit test passed");
        else
            $display("legacy_text_to_utf8_transcoder_unit test failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d output bytes still due.", utf8_due.size());
        $display("legacy_text_to_utf8_transcoder_unit test failed");
        $finish;
    end

endmodule
